// ===== design/wal_pkg.sv =====
// Shared types, constants and the microcode program for the journal tracker.
// No dependencies; imported by wal_seq, wal_dpath and write_ahead_log_tracker.

package wal_pkg;

	localparam int LOG_ENTRIES = 16;
	localparam int CNT_W = 5;
	localparam int IDX_W = (LOG_ENTRIES > 1) ? $clog2(LOG_ENTRIES) : 1;
	localparam int PC_W = 5;
	localparam int COND_W = 4;
	localparam int OP_W = 3;
	localparam int EM_W = 3;
	localparam int BLK_W = 32;
	localparam int LBLK_W = 11;
	localparam int MOB_W = 5;
	localparam int CIDX_W = 2;

	// commands
	localparam logic [1:0] CMD_BEGIN = 2'd0;
	localparam logic [1:0] CMD_WRITE = 2'd1;
	localparam logic [1:0] CMD_END = 2'd2;

	// config register indexes
	localparam logic [CIDX_W-1:0] REG_LOG_START = 2'd0;
	localparam logic [CIDX_W-1:0] REG_LOG_BLOCKS = 2'd1;
	localparam logic [CIDX_W-1:0] REG_MAX_OP = 2'd2;

	// status codes
	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_WAIT = 3'd1;
	localparam logic [2:0] ST_FULL = 3'd2;
	localparam logic [2:0] ST_OUTSIDE = 3'd3;
	localparam logic [2:0] ST_NO_OPEN = 3'd4;

	// action codes
	localparam logic [1:0] ACT_NONE = 2'd0;
	localparam logic [1:0] ACT_COPY = 2'd1;
	localparam logic [1:0] ACT_HDR = 2'd2;

	// branch conditions
	localparam logic [COND_W-1:0] C_NONE = 4'd0;
	localparam logic [COND_W-1:0] C_BEGIN = 4'd1;
	localparam logic [COND_W-1:0] C_WRITE = 4'd2;
	localparam logic [COND_W-1:0] C_END = 4'd3;
	localparam logic [COND_W-1:0] C_REFUSE = 4'd4;
	localparam logic [COND_W-1:0] C_FULL = 4'd5;
	localparam logic [COND_W-1:0] C_NOOPEN = 4'd6;
	localparam logic [COND_W-1:0] C_COMMIT = 4'd7;
	localparam logic [COND_W-1:0] C_SCANDONE = 4'd8;
	localparam logic [COND_W-1:0] C_DRAINED = 4'd9;
	localparam logic [COND_W-1:0] C_HIT = 4'd10;

	// datapath operations
	localparam logic [OP_W-1:0] OP_NONE = 3'd0;
	localparam logic [OP_W-1:0] OP_OPEN_INC = 3'd1;
	localparam logic [OP_W-1:0] OP_OPEN_DEC = 3'd2;
	localparam logic [OP_W-1:0] OP_IDX_CLR = 3'd3;
	localparam logic [OP_W-1:0] OP_SCAN = 3'd4;
	localparam logic [OP_W-1:0] OP_APPEND = 3'd5;
	localparam logic [OP_W-1:0] OP_CNT_CLR = 3'd6;

	// result kinds
	localparam logic [EM_W-1:0] EM_NONE = 3'd0;
	localparam logic [EM_W-1:0] EM_REPLY = 3'd1;
	localparam logic [EM_W-1:0] EM_ABS = 3'd2;
	localparam logic [EM_W-1:0] EM_COPY_OUT = 3'd3;
	localparam logic [EM_W-1:0] EM_HDR_N = 3'd4;
	localparam logic [EM_W-1:0] EM_COPY_IN = 3'd5;
	localparam logic [EM_W-1:0] EM_HDR_0 = 3'd6;

	// program labels
	localparam logic [PC_W-1:0] PC_IDLE = 5'd0;
	localparam logic [PC_W-1:0] PC_DISPATCH = 5'd1;
	localparam logic [PC_W-1:0] PC_BEGIN = 5'd5;
	localparam logic [PC_W-1:0] PC_B_WAIT = 5'd7;
	localparam logic [PC_W-1:0] PC_WRITE = 5'd8;
	localparam logic [PC_W-1:0] PC_W_SEARCH = 5'd11;
	localparam logic [PC_W-1:0] PC_W_ABS = 5'd14;
	localparam logic [PC_W-1:0] PC_W_FULL = 5'd15;
	localparam logic [PC_W-1:0] PC_W_OUTSIDE = 5'd16;
	localparam logic [PC_W-1:0] PC_END = 5'd17;
	localparam logic [PC_W-1:0] PC_E_NOOPEN = 5'd20;
	localparam logic [PC_W-1:0] PC_COMMIT = 5'd21;
	localparam logic [PC_W-1:0] PC_C_OUT = 5'd22;
	localparam logic [PC_W-1:0] PC_C_IN = 5'd25;

	typedef struct packed {
		logic [COND_W-1:0] cond;
		logic              neg;
		logic [PC_W-1:0]   target;
		logic [OP_W-1:0]   op;
		logic [EM_W-1:0]   emit;
		logic [2:0]        status;
		logic              done;
	} uword_t;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic [EM_W-1:0] emit;
		logic [2:0]      status;
	} dp_ctrl_t;

	typedef struct packed {
		logic is_begin;
		logic is_write;
		logic is_end;
		logic refuse;
		logic full;
		logic no_open;
		logic commit;
		logic scan_done;
		logic drained;
		logic hit;
	} dp_flags_t;

	typedef struct packed {
		logic             valid;
		logic [2:0]       status;
		logic [1:0]       action;
		logic [BLK_W-1:0] src;
		logic [BLK_W-1:0] dst;
		logic [CNT_W-1:0] hcount;
		logic             absorbed;
		logic             last;
	} res_t;

	function automatic uword_t uw(input logic [COND_W-1:0] cond, input logic neg,
		input logic [PC_W-1:0] target, input logic [OP_W-1:0] op,
		input logic [EM_W-1:0] emit, input logic [2:0] status, input logic done);
		uword_t w;
		w.cond = cond;
		w.neg = neg;
		w.target = target;
		w.op = op;
		w.emit = emit;
		w.status = status;
		w.done = done;
		return w;
	endfunction

	// control store; step 0 is idle and does nothing
	function automatic uword_t ucode(input logic [PC_W-1:0] pc);
		uword_t w;
		w = '0;
		unique case (pc)
			5'd1: w = uw(C_BEGIN, 1'b0, PC_BEGIN, OP_NONE, EM_NONE, ST_OK, 1'b0);
			5'd2: w = uw(C_WRITE, 1'b0, PC_WRITE, OP_NONE, EM_NONE, ST_OK, 1'b0);
			5'd3: w = uw(C_END, 1'b0, PC_END, OP_NONE, EM_NONE, ST_OK, 1'b0);
			5'd4: w = uw(C_NONE, 1'b0, PC_IDLE, OP_NONE, EM_REPLY, ST_OK, 1'b1);
			// begin
			5'd5: w = uw(C_REFUSE, 1'b0, PC_B_WAIT, OP_NONE, EM_NONE, ST_OK, 1'b0);
			5'd6: w = uw(C_NONE, 1'b0, PC_IDLE, OP_OPEN_INC, EM_REPLY, ST_OK, 1'b1);
			5'd7: w = uw(C_NONE, 1'b0, PC_IDLE, OP_NONE, EM_REPLY, ST_WAIT, 1'b1);
			// block write
			5'd8: w = uw(C_FULL, 1'b0, PC_W_FULL, OP_NONE, EM_NONE, ST_OK, 1'b0);
			5'd9: w = uw(C_NOOPEN, 1'b0, PC_W_OUTSIDE, OP_NONE, EM_NONE, ST_OK, 1'b0);
			5'd10: w = uw(C_NONE, 1'b0, PC_IDLE, OP_IDX_CLR, EM_NONE, ST_OK, 1'b0);
			5'd11: w = uw(C_SCANDONE, 1'b1, PC_W_SEARCH, OP_SCAN, EM_NONE, ST_OK, 1'b0);
			5'd12: w = uw(C_HIT, 1'b0, PC_W_ABS, OP_NONE, EM_NONE, ST_OK, 1'b0);
			5'd13: w = uw(C_NONE, 1'b0, PC_IDLE, OP_APPEND, EM_REPLY, ST_OK, 1'b1);
			5'd14: w = uw(C_NONE, 1'b0, PC_IDLE, OP_NONE, EM_ABS, ST_OK, 1'b1);
			5'd15: w = uw(C_NONE, 1'b0, PC_IDLE, OP_NONE, EM_REPLY, ST_FULL, 1'b1);
			5'd16: w = uw(C_NONE, 1'b0, PC_IDLE, OP_NONE, EM_REPLY, ST_OUTSIDE, 1'b1);
			// end
			5'd17: w = uw(C_NOOPEN, 1'b0, PC_E_NOOPEN, OP_NONE, EM_NONE, ST_OK, 1'b0);
			5'd18: w = uw(C_COMMIT, 1'b0, PC_COMMIT, OP_OPEN_DEC, EM_NONE, ST_OK, 1'b0);
			5'd19: w = uw(C_NONE, 1'b0, PC_IDLE, OP_NONE, EM_REPLY, ST_OK, 1'b1);
			5'd20: w = uw(C_NONE, 1'b0, PC_IDLE, OP_NONE, EM_REPLY, ST_NO_OPEN, 1'b1);
			// commit run
			5'd21: w = uw(C_NONE, 1'b0, PC_IDLE, OP_IDX_CLR, EM_NONE, ST_OK, 1'b0);
			5'd22: w = uw(C_DRAINED, 1'b1, PC_C_OUT, OP_SCAN, EM_COPY_OUT, ST_OK, 1'b0);
			5'd23: w = uw(C_NONE, 1'b0, PC_IDLE, OP_NONE, EM_HDR_N, ST_OK, 1'b0);
			5'd24: w = uw(C_NONE, 1'b0, PC_IDLE, OP_IDX_CLR, EM_NONE, ST_OK, 1'b0);
			5'd25: w = uw(C_DRAINED, 1'b1, PC_C_IN, OP_SCAN, EM_COPY_IN, ST_OK, 1'b0);
			5'd26: w = uw(C_NONE, 1'b0, PC_IDLE, OP_CNT_CLR, EM_HDR_0, ST_OK, 1'b1);
			default: w = '0;
		endcase
		return w;
	endfunction

endpackage

// ===== design/wal_seq.sv =====
// Microcode sequencer: step counter, control store lookup and branch select.
// Depends on wal_pkg for the control word layout and program.

module wal_seq import wal_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      accept,
	input  dp_flags_t flags,
	output dp_ctrl_t  ctrl,
	output logic      busy
);

	logic [PC_W-1:0] pc_q;
	logic [PC_W-1:0] pc_nxt;
	uword_t          word;
	logic            flag;

	always_comb begin
		word = ucode(pc_q);
		unique case (word.cond)
			C_BEGIN:    flag = flags.is_begin;
			C_WRITE:    flag = flags.is_write;
			C_END:      flag = flags.is_end;
			C_REFUSE:   flag = flags.refuse;
			C_FULL:     flag = flags.full;
			C_NOOPEN:   flag = flags.no_open;
			C_COMMIT:   flag = flags.commit;
			C_SCANDONE: flag = flags.scan_done;
			C_DRAINED:  flag = flags.drained;
			C_HIT:      flag = flags.hit;
			default:    flag = 1'b0;
		endcase

		if (pc_q == PC_IDLE) begin
			pc_nxt = accept ? PC_DISPATCH : PC_IDLE;
		end else if (word.done) begin
			pc_nxt = PC_IDLE;
		end else if ((word.cond != C_NONE) && (flag ^ word.neg)) begin
			pc_nxt = word.target;
		end else begin
			pc_nxt = pc_q + PC_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= PC_IDLE;
		end else begin
			pc_q <= pc_nxt;
		end
	end

	assign ctrl.op = word.op;
	assign ctrl.emit = word.emit;
	assign ctrl.status = word.status;
	assign busy = (pc_q != PC_IDLE);

endmodule

// ===== design/wal_dpath.sv =====
// Datapath: config registers, logged block table, counters, scan pipeline
// and result formation. Depends on wal_pkg.

module wal_dpath import wal_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  logic [1:0]        cmd,
	input  logic [BLK_W-1:0]  block_number,
	input  logic              cfg_we,
	input  logic [CIDX_W-1:0] cfg_index,
	input  logic [BLK_W-1:0]  cfg_data,
	input  dp_ctrl_t          ctrl,
	output dp_flags_t         flags,
	output res_t              res
);

	logic [BLK_W-1:0]  log_start_q;
	logic [LBLK_W-1:0] log_blocks_q;
	logic [MOB_W-1:0]  max_op_q;

	logic [BLK_W-1:0]  tbl [LOG_ENTRIES];
	logic [CNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]  open_q;
	logic [CNT_W-1:0]  idx_q;
	logic [CNT_W-1:0]  slot_q;
	logic              pv_q;
	logic              hit_q;
	logic [BLK_W-1:0]  rd_q;
	logic [1:0]        cmd_q;
	logic [BLK_W-1:0]  blk_q;

	logic [11:0]       need;
	logic              match_c;
	logic              in_range;
	logic [BLK_W-1:0]  slot_addr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			log_start_q <= '0;
			log_blocks_q <= LBLK_W'(17);
			max_op_q <= MOB_W'(4);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_LOG_START:  log_start_q <= cfg_data;
				REG_LOG_BLOCKS: log_blocks_q <= cfg_data[LBLK_W-1:0];
				REG_MAX_OP:     max_op_q <= cfg_data[MOB_W-1:0];
				default:        ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cmd_q <= cmd;
			blk_q <= block_number;
		end
		if (ctrl.op == OP_APPEND) begin
			tbl[cnt_q[IDX_W-1:0]] <= blk_q;
		end
		if (ctrl.op == OP_SCAN) begin
			rd_q <= tbl[idx_q[IDX_W-1:0]];
			slot_q <= idx_q;
		end
	end

	assign in_range = (idx_q < cnt_q);
	assign match_c = pv_q && (rd_q == blk_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			open_q <= '0;
			idx_q <= '0;
			pv_q <= 1'b0;
			hit_q <= 1'b0;
		end else begin
			case (ctrl.op)
				OP_OPEN_INC: open_q <= open_q + CNT_W'(1);
				OP_OPEN_DEC: open_q <= open_q - CNT_W'(1);
				OP_APPEND:   cnt_q <= cnt_q + CNT_W'(1);
				OP_CNT_CLR:  cnt_q <= '0;
				OP_IDX_CLR: begin
					idx_q <= '0;
					pv_q <= 1'b0;
					hit_q <= 1'b0;
				end
				OP_SCAN: begin
					pv_q <= in_range;
					hit_q <= match_c;
					if (in_range) begin
						idx_q <= idx_q + CNT_W'(1);
					end
				end
				default: ;
			endcase
		end
	end

	// admission: entries + (open + 1) * worst case must fit
	assign need = 12'(cnt_q) + (12'(open_q) + 12'd1) * 12'(max_op_q);

	always_comb begin
		flags.is_begin = (cmd_q == CMD_BEGIN);
		flags.is_write = (cmd_q == CMD_WRITE);
		flags.is_end = (cmd_q == CMD_END);
		flags.refuse = (open_q == '1) || (need > 12'(LOG_ENTRIES));
		flags.full = (cnt_q >= CNT_W'(LOG_ENTRIES)) ||
			((12'(cnt_q) + 12'd1) >= 12'(log_blocks_q));
		flags.no_open = (open_q == '0);
		flags.commit = (open_q == CNT_W'(1)) && (cnt_q != '0);
		flags.drained = (idx_q == cnt_q) && !pv_q;
		flags.scan_done = match_c || flags.drained;
		flags.hit = hit_q;
	end

	assign slot_addr = log_start_q + BLK_W'(slot_q) + BLK_W'(1);

	always_comb begin
		res = '0;
		case (ctrl.emit)
			EM_REPLY: begin
				res.valid = 1'b1;
				res.status = ctrl.status;
				res.last = 1'b1;
			end
			EM_ABS: begin
				res.valid = 1'b1;
				res.absorbed = 1'b1;
				res.last = 1'b1;
			end
			EM_COPY_OUT: begin
				res.valid = pv_q;
				res.action = ACT_COPY;
				res.src = rd_q;
				res.dst = slot_addr;
			end
			EM_COPY_IN: begin
				res.valid = pv_q;
				res.action = ACT_COPY;
				res.src = slot_addr;
				res.dst = rd_q;
			end
			EM_HDR_N: begin
				res.valid = 1'b1;
				res.action = ACT_HDR;
				res.hcount = cnt_q;
			end
			EM_HDR_0: begin
				res.valid = 1'b1;
				res.action = ACT_HDR;
				res.last = 1'b1;
			end
			default: ;
		endcase
	end

endmodule

// ===== design/write_ahead_log_tracker.sv =====
// Top level of the journal group-commit tracker: handshake, result register.
// Depends on wal_pkg, wal_seq and wal_dpath.
//
// Usage: raise start with cmd and block_number; the command is taken at a
// clock edge where start is high and busy is low. Results come out one per
// strobe cycle on status/action/source_block/dest_block/header_count/absorbed,
// with last marking the final result of the command; the receiver cannot
// stall, so every strobe must be consumed in its cycle.
// Per command: a write compares one table entry per cycle, and a commit
// reads one table entry per cycle, each pass emitting one copy per entry.
// The microcode step counter runs one step per cycle; busy drops when the
// last result is registered, so the next command can be accepted while
// that result is on the ports.
// Config writes (cfg_we, cfg_index, cfg_data) take effect at once; the user
// must make them while busy is low, which the block itself does not enforce.
// Reset clears the counters and config to defaults; the block table needs
// no clearing because only entries below the count are ever used.

module write_ahead_log_tracker import wal_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [1:0]        cmd,
	input  logic [BLK_W-1:0]  block_number,
	input  logic              cfg_we,
	input  logic [CIDX_W-1:0] cfg_index,
	input  logic [BLK_W-1:0]  cfg_data,
	output logic              strobe,
	output logic [2:0]        status,
	output logic [1:0]        action,
	output logic [BLK_W-1:0]  source_block,
	output logic [BLK_W-1:0]  dest_block,
	output logic [CNT_W-1:0]  header_count,
	output logic              absorbed,
	output logic              last
);

	logic      accept;
	dp_ctrl_t  ctrl;
	dp_flags_t flags;
	res_t      res;
	res_t      out_q;
	logic      strobe_q;

	assign accept = start && !busy;

	wal_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.flags  (flags),
		.ctrl   (ctrl),
		.busy   (busy)
	);

	wal_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (accept),
		.cmd          (cmd),
		.block_number (block_number),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.ctrl         (ctrl),
		.flags        (flags),
		.res          (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= res.valid;
		end
	end

	always_ff @(posedge clk) begin
		out_q <= res;
	end

	assign strobe = strobe_q;
	assign status = out_q.status;
	assign action = out_q.action;
	assign source_block = out_q.src;
	assign dest_block = out_q.dst;
	assign header_count = out_q.hcount;
	assign absorbed = out_q.absorbed;
	assign last = out_q.last;

	// results only come from a command in progress
	a_strobe_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(busy))
		else $error("result without a command in progress");

	// the final result of a run coincides with the sequencer going idle
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last |-> !busy)
		else $error("last result while sequencer still busy");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted command did not start the sequencer");

	a_hdr_count: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && (action == ACT_HDR) |-> header_count <= CNT_W'(LOG_ENTRIES))
		else $error("header count exceeds table size");

endmodule

// ===== tb/sv/tb_write_ahead_log_tracker.sv =====
// Self-checking testbench for write_ahead_log_tracker: directed table, then random phases.
// Predicts every result of each accepted transaction and checks results in order.
// Depends on wal_pkg and the write_ahead_log_tracker RTL.

module tb_write_ahead_log_tracker;
	timeunit 1ns;
	timeprecision 1ps;
	import wal_pkg::*;

	localparam logic [1:0] CMD_UNKNOWN = 2'd3;

	typedef struct packed {
		logic [2:0]       status;
		logic [1:0]       action;
		logic [BLK_W-1:0] src;
		logic [BLK_W-1:0] dst;
		logic [CNT_W-1:0] hcount;
		logic             absorbed;
		logic             last;
	} journal_res_t;

	typedef struct packed {
		logic              is_cfg;
		logic [1:0]        op;
		logic [BLK_W-1:0]  blk;
		logic [LBLK_W-1:0] lb;
		logic [MOB_W-1:0]  mo;
		logic              typed;
		logic [2:0]        t_status;
	} plan_row_t;

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	logic [1:0]        cmd;
	logic [BLK_W-1:0]  block_number;
	logic              cfg_we;
	logic [CIDX_W-1:0] cfg_index;
	logic [BLK_W-1:0]  cfg_data;
	logic              strobe;
	logic [2:0]        status;
	logic [1:0]        action;
	logic [BLK_W-1:0]  source_block;
	logic [BLK_W-1:0]  dest_block;
	logic [CNT_W-1:0]  header_count;
	logic              absorbed;
	logic              last;

	// predicted journal state and register copy
	logic [BLK_W-1:0]  jrnl_blocks [LOG_ENTRIES];
	int                jrnl_count;
	int                jrnl_open;
	logic [BLK_W-1:0]  cfg_log_start;
	logic [LBLK_W-1:0] cfg_log_blocks;
	logic [MOB_W-1:0]  cfg_max_op;

	journal_res_t      step_results [$];
	journal_res_t      pending_results [$];
	plan_row_t         plan [$];
	logic [BLK_W-1:0]  blk_pool [8];
	int                fail_count = 0;
	int                items_sent;
	bit                quiet;

	write_ahead_log_tracker dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.block_number(block_number),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.strobe(strobe),
		.status(status),
		.action(action),
		.source_block(source_block),
		.dest_block(dest_block),
		.header_count(header_count),
		.absorbed(absorbed),
		.last(last)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	function automatic journal_res_t mk_result(input logic [2:0] st, input logic [1:0] act,
		input logic [BLK_W-1:0] src, input logic [BLK_W-1:0] dst,
		input logic [CNT_W-1:0] hc, input logic ab, input logic lst);
		journal_res_t r;
		r.status = st;
		r.action = act;
		r.src = src;
		r.dst = dst;
		r.hcount = hc;
		r.absorbed = ab;
		r.last = lst;
		return r;
	endfunction

	// advance the journal state by one command, results into step_results
	function automatic void step_journal(input logic [1:0] op, input logic [BLK_W-1:0] blk);
		int need;
		bit hit;
		step_results.delete();
		case (op)
			CMD_BEGIN: begin
				need = jrnl_count + (jrnl_open + 1) * int'(cfg_max_op);
				if (jrnl_open >= 31 || need > LOG_ENTRIES) begin
					step_results.push_back(mk_result(ST_WAIT, ACT_NONE, 0, 0, 0, 0, 1));
				end else begin
					jrnl_open++;
					step_results.push_back(mk_result(ST_OK, ACT_NONE, 0, 0, 0, 0, 1));
				end
			end
			CMD_WRITE: begin
				hit = 0;
				if (jrnl_count >= LOG_ENTRIES || jrnl_count + 1 >= int'(cfg_log_blocks)) begin
					step_results.push_back(mk_result(ST_FULL, ACT_NONE, 0, 0, 0, 0, 1));
				end else if (jrnl_open < 1) begin
					step_results.push_back(mk_result(ST_OUTSIDE, ACT_NONE, 0, 0, 0, 0, 1));
				end else begin
					for (int i = 0; i < jrnl_count; i++)
						if (jrnl_blocks[i] == blk)
							hit = 1;
					if (!hit) begin
						jrnl_blocks[jrnl_count] = blk;
						jrnl_count++;
					end
					step_results.push_back(mk_result(ST_OK, ACT_NONE, 0, 0, 0, hit, 1));
				end
			end
			CMD_END: begin
				if (jrnl_open == 0) begin
					step_results.push_back(mk_result(ST_NO_OPEN, ACT_NONE, 0, 0, 0, 0, 1));
				end else begin
					jrnl_open--;
					if (jrnl_open != 0 || jrnl_count == 0) begin
						step_results.push_back(mk_result(ST_OK, ACT_NONE, 0, 0, 0, 0, 1));
					end else begin
						// group commit: log out, header, install home, clear header
						for (int i = 0; i < jrnl_count; i++)
							step_results.push_back(mk_result(ST_OK, ACT_COPY, jrnl_blocks[i],
								cfg_log_start + BLK_W'(1 + i), 0, 0, 0));
						step_results.push_back(mk_result(ST_OK, ACT_HDR, 0, 0,
							CNT_W'(jrnl_count), 0, 0));
						for (int i = 0; i < jrnl_count; i++)
							step_results.push_back(mk_result(ST_OK, ACT_COPY,
								cfg_log_start + BLK_W'(1 + i), jrnl_blocks[i], 0, 0, 0));
						step_results.push_back(mk_result(ST_OK, ACT_HDR, 0, 0, 0, 0, 1));
						jrnl_count = 0;
					end
				end
			end
			default: begin
				step_results.push_back(mk_result(ST_OK, ACT_NONE, 0, 0, 0, 0, 1));
			end
		endcase
	endfunction

	function automatic void add_row(input logic is_cfg, input logic [1:0] op,
		input logic [BLK_W-1:0] blk, input logic [LBLK_W-1:0] lb,
		input logic [MOB_W-1:0] mo, input logic typed, input logic [2:0] t_status);
		plan_row_t r;
		r.is_cfg = is_cfg;
		r.op = op;
		r.blk = blk;
		r.lb = lb;
		r.mo = mo;
		r.typed = typed;
		r.t_status = t_status;
		plan.push_back(r);
	endfunction

	task automatic check_field(input string fname, input logic [BLK_W-1:0] exp_v,
		input logic [BLK_W-1:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s mismatch: expected %h, actual %h", $time, fname, exp_v, act_v);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin
		journal_res_t want;
		if (arst_n === 1'b1 && strobe === 1'b1) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result: expected none, actual status %h action %h",
					$time, status, action);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				check_field("status", want.status, status);
				check_field("action", want.action, action);
				check_field("source_block", want.src, source_block);
				check_field("dest_block", want.dst, dest_block);
				check_field("header_count", want.hcount, header_count);
				check_field("absorbed", want.absorbed, absorbed);
				check_field("last", want.last, last);
			end
		end
	end

	// one command transaction; returns in the time step of acceptance
	task automatic send_item(input logic [1:0] op, input logic [BLK_W-1:0] blk,
		input logic typed, input logic [2:0] t_status);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 16);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		cmd <= op;
		block_number <= blk;
		@(posedge clk);
		while (busy !== 1'b0) @(posedge clk);
		step_journal(op, blk);
		if (typed)
			pending_results.push_back(mk_result(t_status, ACT_NONE, 0, 0, 0, 0, 1));
		else
			foreach (step_results[i]) pending_results.push_back(step_results[i]);
		if (op != CMD_UNKNOWN)
			items_sent++;
	endtask

	task automatic drain();
		if (start)
			start <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0 || busy !== 1'b0);
	endtask

	task automatic set_cfg(input logic [BLK_W-1:0] ls, input logic [LBLK_W-1:0] lb,
		input logic [MOB_W-1:0] mo);
		cfg_we <= 1'b1;
		cfg_index <= REG_LOG_START;
		cfg_data <= ls;
		@(posedge clk);
		cfg_index <= REG_LOG_BLOCKS;
		cfg_data <= BLK_W'(lb);
		@(posedge clk);
		cfg_index <= REG_MAX_OP;
		cfg_data <= BLK_W'(mo);
		@(posedge clk);
		cfg_we <= 1'b0;
		cfg_log_start = ls;
		cfg_log_blocks = lb;
		cfg_max_op = mo;
	endtask

	function automatic logic [BLK_W-1:0] pick_block();
		if ($urandom_range(0, 1) == 0)
			return blk_pool[$urandom_range(0, 7)];
		return $urandom;
	endfunction

	// mostly well-formed groups with random content, some noise
	task automatic run_group();
		int nops;
		logic [1:0] op;
		quiet = ($urandom_range(0, 3) == 0);
		if ($urandom_range(0, 5) == 0) begin
			repeat ($urandom_range(1, 4)) begin
				op = 2'($urandom_range(0, 3));
				send_item(op, pick_block(), 1'b0, ST_OK);
			end
		end else begin
			nops = $urandom_range(1, 4);
			repeat (nops) send_item(CMD_BEGIN, $urandom, 1'b0, ST_OK);
			repeat ($urandom_range(0, 18)) send_item(CMD_WRITE, pick_block(), 1'b0, ST_OK);
			repeat (nops) send_item(CMD_END, $urandom, 1'b0, ST_OK);
		end
		if ($urandom_range(0, 15) == 0)
			drain();
	endtask

	task automatic run_phase(input logic [BLK_W-1:0] ls, input logic [LBLK_W-1:0] lb,
		input logic [MOB_W-1:0] mo, input int quota);
		drain();
		set_cfg(ls, lb, mo);
		blk_pool[0] = '0;
		blk_pool[1] = '1;
		for (int i = 2; i < 8; i++)
			blk_pool[i] = $urandom;
		items_sent = 0;
		while (items_sent < quota) run_group();
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		cmd = CMD_BEGIN;
		block_number = '0;
		cfg_we = 1'b0;
		cfg_index = REG_LOG_START;
		cfg_data = '0;
		quiet = 0;
		items_sent = 0;
		cfg_log_start = '0;
		cfg_log_blocks = 11'd17;
		cfg_max_op = 5'd4;
		jrnl_count = 0;
		jrnl_open = 0;
		foreach (jrnl_blocks[i]) jrnl_blocks[i] = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: error codes from reset, unknown command, empty group, admission, absorb, commit
		add_row(0, CMD_END, 32'h0, 0, 0, 1, ST_NO_OPEN);
		add_row(0, CMD_WRITE, 32'hFFFF_FFFF, 0, 0, 1, ST_OUTSIDE);
		add_row(0, CMD_UNKNOWN, 32'h8000_0001, 0, 0, 1, ST_OK);
		add_row(0, CMD_BEGIN, 32'h0, 0, 0, 1, ST_OK);
		add_row(0, CMD_END, 32'h0, 0, 0, 1, ST_OK);
		repeat (4) add_row(0, CMD_BEGIN, 32'h0, 0, 0, 0, ST_OK);
		add_row(0, CMD_BEGIN, 32'h0, 0, 0, 1, ST_WAIT);
		add_row(0, CMD_WRITE, 32'h0000_0000, 0, 0, 0, ST_OK);
		add_row(0, CMD_WRITE, 32'hFFFF_FFFF, 0, 0, 0, ST_OK);
		add_row(0, CMD_WRITE, 32'h0000_0000, 0, 0, 0, ST_OK);
		add_row(0, CMD_WRITE, 32'h5555_AAAA, 0, 0, 0, ST_OK);
		add_row(0, CMD_WRITE, 32'hAAAA_5555, 0, 0, 0, ST_OK);
		repeat (4) add_row(0, CMD_END, 32'h0, 0, 0, 0, ST_OK);
		add_row(0, CMD_END, 32'h0, 0, 0, 1, ST_NO_OPEN);
		// tiny log at the top of the block space: one entry fills it
		add_row(1, CMD_BEGIN, 32'hFFFF_FFFE, 11'd2, 5'd16, 0, ST_OK);
		add_row(0, CMD_BEGIN, 32'h0, 0, 0, 0, ST_OK);
		add_row(0, CMD_BEGIN, 32'h0, 0, 0, 1, ST_WAIT);
		add_row(0, CMD_WRITE, 32'h0000_1234, 0, 0, 0, ST_OK);
		add_row(0, CMD_WRITE, 32'h0000_1234, 0, 0, 1, ST_FULL);
		add_row(0, CMD_END, 32'h0, 0, 0, 0, ST_OK);

		foreach (plan[i]) begin
			if (plan[i].is_cfg) begin
				drain();
				set_cfg(plan[i].blk, plan[i].lb, plan[i].mo);
			end else begin
				send_item(plan[i].op, plan[i].blk, plan[i].typed, plan[i].t_status);
			end
		end

		run_phase($urandom, 11'd17, 5'd4, 50);
		run_phase(32'hFFFF_FFF8, 11'd1024, 5'd1, 50);
		run_phase(32'h0, 11'd2, 5'd16, 40);

		// zero budget per operation: open count runs into saturation
		drain();
		set_cfg($urandom, 11'd18, 5'd0);
		quiet = 0;
		repeat (32) send_item(CMD_BEGIN, $urandom, 1'b0, ST_OK);
		repeat (3) send_item(CMD_WRITE, $urandom, 1'b0, ST_OK);
		repeat (32) send_item(CMD_END, $urandom, 1'b0, ST_OK);

		run_phase($urandom, 11'($urandom_range(2, 20)), 5'($urandom_range(1, 16)), 50);

		drain();
		repeat (60) @(posedge clk);
		if (fail_count == 0 && pending_results.size() == 0) begin
			$display("write_ahead_log_tracker test passed");
		end else begin
			$display("write_ahead_log_tracker test failed");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
		$display("write_ahead_log_tracker test failed");
		$finish;
	end

endmodule
